>>> sv/ulpt_pkg.sv
// ----------------------------------------------------------------------------
// UDP port listener table: shared definitions
// Types, codes and constants used by the cells, the chain and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ulpt_pkg;

  // Table size used when the top level is not told otherwise.
  localparam int ENTRIES_DEFAULT = 64;

  // Fixed field widths.
  localparam int PORT_W   = 16;
  localparam int HANDLE_W = 16;
  localparam int LEN_W    = 16;
  localparam int IP_W     = 32;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 2;

  // Bytes taken by the UDP header.
  localparam logic [LEN_W-1:0] UDP_HDR_BYTES = LEN_W'(8);

  // Request kinds. The fourth code is unused and treated as a miss.
  typedef enum logic [KIND_W-1:0] {
    KIND_REGISTER   = 2'd0,
    KIND_UNREGISTER = 2'd1,
    KIND_DELIVER    = 2'd2
  } kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NULL_HANDLE = 3'd1,
    ST_PORT_IN_USE = 3'd2,
    ST_TABLE_FULL  = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_TOO_SHORT   = 3'd5
  } status_t;

  // Control sequencer states.
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_COMMIT
  } fsm_t;

  // Search token that walks the cell chain one cell per cycle.
  typedef struct packed {
    logic                active;
    logic [PORT_W-1:0]   port;
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic                free_seen;
  } tok_t;

  // Write command broadcast to all cells; the entry index travels beside it.
  typedef struct packed {
    logic                en;
    logic                set;
    logic [PORT_W-1:0]   port;
    logic [HANDLE_W-1:0] handle;
  } wr_t;

endpackage

`default_nettype wire

>>> sv/ulpt_cell.sv
// ----------------------------------------------------------------------------
// UDP port listener table: one table cell
// Holds one entry, checks the passing search token against it and hands the
// token on to the next cell through its token stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module ulpt_cell import ulpt_pkg::*; #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tok_t          tok_in,
  input  wire logic [IW-1:0] hit_idx_in,
  input  wire logic [IW-1:0] free_idx_in,
  output tok_t               tok_out,
  output logic [IW-1:0]      hit_idx_out,
  output logic [IW-1:0]      free_idx_out,
  input  wire wr_t           wr,
  input  wire logic [IW-1:0] wr_idx
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                valid;
  logic [PORT_W-1:0]   eport;
  logic [HANDLE_W-1:0] ehandle;

  tok_t          tok_next;
  logic [IW-1:0] hit_idx_next;
  logic [IW-1:0] free_idx_next;
  logic          match;
  logic          vacant;

  // The first valid entry with the same port wins; the first vacant one is
  // remembered as the free slot.
  always_comb begin
    match         = valid && (eport == tok_in.port) && !tok_in.hit;
    vacant        = !valid && !tok_in.free_seen;
    tok_next      = tok_in;
    hit_idx_next  = hit_idx_in;
    free_idx_next = free_idx_in;
    if (match) begin
      tok_next.hit    = 1'b1;
      tok_next.handle = ehandle;
      hit_idx_next    = MY_IDX;
    end
    if (vacant) begin
      tok_next.free_seen = 1'b1;
      free_idx_next      = MY_IDX;
    end
  end

  // Token stage register; reset empties the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
    hit_idx_out  <= hit_idx_next;
    free_idx_out <= free_idx_next;
  end

  // Entry storage; only the valid mark is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && (wr_idx == MY_IDX)) begin
      valid <= wr.set;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.set && (wr_idx == MY_IDX)) begin
      eport   <= wr.port;
      ehandle <= wr.handle;
    end
  end

endmodule

`default_nettype wire

>>> sv/ulpt_chain.sv
// ----------------------------------------------------------------------------
// UDP port listener table: cell chain
// A row of table cells; the search token enters at cell zero and passes the
// stage register of every cell in turn before it leaves the last cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ulpt_chain import ulpt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT,
  parameter int IW      = $clog2(ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tok_t          tok_in,
  output tok_t               tok_out,
  output logic [IW-1:0]      hit_idx,
  output logic [IW-1:0]      free_idx,
  input  wire wr_t           wr,
  input  wire logic [IW-1:0] wr_idx
);

  tok_t          tok  [ENTRIES+1];
  logic [IW-1:0] hidx [ENTRIES+1];
  logic [IW-1:0] fidx [ENTRIES+1];

  assign tok[0]  = tok_in;
  assign hidx[0] = '0;
  assign fidx[0] = '0;

  // One cell per table entry, each feeding its right-hand neighbor.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ulpt_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .tok_in       (tok[i]),
      .hit_idx_in   (hidx[i]),
      .free_idx_in  (fidx[i]),
      .tok_out      (tok[i+1]),
      .hit_idx_out  (hidx[i+1]),
      .free_idx_out (fidx[i+1]),
      .wr           (wr),
      .wr_idx       (wr_idx)
    );
  end

  assign tok_out  = tok[ENTRIES];
  assign hit_idx  = hidx[ENTRIES];
  assign free_idx = fidx[ENTRIES];

endmodule

`default_nettype wire

>>> sv/udp_port_listener_table_unit.sv
// ----------------------------------------------------------------------------
// UDP port listener table
// Registers and removes port listeners and looks up the listener of an
// incoming datagram, using a chain of table cells walked by a search token.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                    Fields
//  -------  ---------------------------  ------------------------------------
//  item     item_valid / item_stall      kind port handle remote_port src_ip
//                                        header_length total_length
//  result   result_valid / result_stall  status slot listener payload_length
//                                        peer_ip peer_port
//
// One request at a time: the request is captured and the search token launched
// from a register, the token passes every cell of the chain once, the outcome
// is captured as it leaves the last cell, and the result is loaded in the
// commit state. A new request is taken only once the sequencer is back in idle.
// Reset clears every entry's valid mark at once; no clearing pass is needed.
// The next request is taken while a finished result still waits; a stalled
// result holds the table update and the sequencer until it has left.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_port_listener_table_unit import ulpt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire logic [KIND_W-1:0]   kind,
  input  wire logic [PORT_W-1:0]   port,
  input  wire logic [HANDLE_W-1:0] handle,
  input  wire logic [PORT_W-1:0]   remote_port,
  input  wire logic [IP_W-1:0]     src_ip,
  input  wire logic [LEN_W-1:0]    header_length,
  input  wire logic [LEN_W-1:0]    total_length,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [SLOT_W-1:0]        slot,
  output logic [HANDLE_W-1:0]      listener,
  output logic [LEN_W-1:0]         payload_length,
  output logic [IP_W-1:0]          peer_ip,
  output logic [PORT_W-1:0]        peer_port
);

  localparam int IW = $clog2(ENTRIES);

  fsm_t state;
  fsm_t state_next;

  // Request held for the whole search.
  logic [KIND_W-1:0]   kind_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [PORT_W-1:0]   remote_port_q;
  logic [IP_W-1:0]     src_ip_q;
  logic [LEN_W-1:0]    header_length_q;
  logic [LEN_W-1:0]    total_length_q;

  // Token launched into the chain and the one that came out.
  tok_t          launch;
  tok_t          chain_out;
  logic [IW-1:0] chain_hit_idx;
  logic [IW-1:0] chain_free_idx;
  tok_t          found;
  logic [IW-1:0] found_hit_idx;
  logic [IW-1:0] found_free_idx;

  wr_t           wr;
  logic [IW-1:0] wr_idx;

  logic                accept;
  logic                load_result;
  logic                result_take;
  status_t             status_next;
  logic [IW-1:0]       slot_idx;
  logic [HANDLE_W-1:0] listener_next;
  logic [LEN_W-1:0]    payload_next;
  logic [IP_W-1:0]     peer_ip_next;
  logic [PORT_W-1:0]   peer_port_next;
  logic [LEN_W-1:0]    min_len;
  logic [SLOT_W+IW-1:0] slot_wide;

  assign item_stall  = (state != FSM_IDLE);
  assign accept      = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;

  // Capture the request and launch the search token.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q          <= kind;
      handle_q        <= handle;
      remote_port_q   <= remote_port;
      src_ip_q        <= src_ip;
      header_length_q <= header_length;
      total_length_q  <= total_length;
      launch.port     <= port;
    end
    launch.hit       <= 1'b0;
    launch.handle    <= '0;
    launch.free_seen <= 1'b0;
    launch.active    <= accept && !rst;
  end

  ulpt_chain #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .tok_in   (launch),
    .tok_out  (chain_out),
    .hit_idx  (chain_hit_idx),
    .free_idx (chain_free_idx),
    .wr       (wr),
    .wr_idx   (wr_idx)
  );

  // Keep the search outcome once the token leaves the last cell.
  always_ff @(posedge clk) begin
    if (chain_out.active) begin
      found          <= chain_out;
      found_hit_idx  <= chain_hit_idx;
      found_free_idx <= chain_free_idx;
    end
  end

  // Shorter of the two lengths.
  assign min_len = (header_length_q < total_length_q) ? header_length_q : total_length_q;

  // Sequencer next state, table update and result decision.
  always_comb begin
    state_next     = state;
    load_result    = 1'b0;
    status_next    = ST_NOT_FOUND;
    slot_idx       = '0;
    listener_next  = '0;
    payload_next   = '0;
    peer_ip_next   = '0;
    peer_port_next = '0;
    wr.en          = 1'b0;
    wr.set         = 1'b0;
    wr.port        = found.port;
    wr.handle      = handle_q;
    wr_idx         = found_free_idx;

    unique case (kind_q)
      KIND_REGISTER: begin
        if (handle_q == '0) begin
          status_next = ST_NULL_HANDLE;
        end else if (found.hit) begin
          status_next = ST_PORT_IN_USE;
        end else if (!found.free_seen) begin
          status_next = ST_TABLE_FULL;
        end else begin
          status_next = ST_OK;
          slot_idx    = found_free_idx;
        end
      end
      KIND_UNREGISTER: begin
        if (found.hit) begin
          status_next = ST_OK;
          slot_idx    = found_hit_idx;
          wr_idx      = found_hit_idx;
        end
      end
      KIND_DELIVER: begin
        if (total_length_q < UDP_HDR_BYTES) begin
          status_next = ST_TOO_SHORT;
        end else if (found.hit) begin
          status_next    = ST_OK;
          slot_idx       = found_hit_idx;
          listener_next  = found.handle;
          payload_next   = (min_len >= UDP_HDR_BYTES) ? (min_len - UDP_HDR_BYTES) : '0;
          peer_ip_next   = src_ip_q;
          peer_port_next = remote_port_q;
        end
      end
      default: begin
        status_next = ST_NOT_FOUND;
      end
    endcase

    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          state_next = FSM_SEARCH;
        end
      end
      FSM_SEARCH: begin
        if (chain_out.active) begin
          state_next = FSM_COMMIT;
        end
      end
      FSM_COMMIT: begin
        if (!result_valid || !result_stall) begin
          load_result = 1'b1;
          state_next  = FSM_IDLE;
          if (status_next == ST_OK) begin
            if (kind_q == KIND_REGISTER) begin
              wr.en  = 1'b1;
              wr.set = 1'b1;
            end else if (kind_q == KIND_UNREGISTER) begin
              wr.en  = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Slot is the entry index cut or padded to the slot field.
  assign slot_wide = {{SLOT_W{1'b0}}, slot_idx};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      status         <= status_next;
      slot           <= slot_wide[SLOT_W-1:0];
      listener       <= listener_next;
      payload_length <= payload_next;
      peer_ip        <= peer_ip_next;
      peer_port      <= peer_port_next;
    end
  end

`ifndef SYNTHESIS
  // The token only leaves the chain while the sequencer waits for it.
  a_token_in_search: assert property (@(posedge clk) disable iff (rst)
    chain_out.active |-> (state == FSM_SEARCH))
    else $error("search token left the chain outside the search state");

  // A table write always comes with a successful result.
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> (result_valid && (status == ST_OK)))
    else $error("table written without a successful result");

  // A failed request reports slot zero and no listener.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != ST_OK)) |-> ((slot == '0) && (listener == '0)))
    else $error("failed request reported a slot or listener");
`endif

endmodule

`default_nettype wire
